@@ rtl/core/led64_block_encrypt_defines.svh @@
// Assertion macros shared by the LED-64 RTL; they expect clk_i and rst_ni in scope.
`ifndef LED64_BLOCK_ENCRYPT_DEFINES_SVH
`define LED64_BLOCK_ENCRYPT_DEFINES_SVH

// Property checked on every rising edge, disabled while reset is asserted.
`define LED64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define LED64_ASSERT_NEVER(lbl, expr, msg) \
  `LED64_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/core/led64_pkg.sv @@
// Types, constants and GF(16) helpers for the LED-64 block encryptor.
`timescale 1ns / 1ps
`default_nettype none

package led64_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int RC_SLOTS    = 32;
  localparam int RC_W        = 6;
  localparam int CFG_IDX_W   = 3;

  typedef logic [63:0]      block_t;
  typedef logic [RC_W-1:0]  rc_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_CIPHER_KEY = 3'd0;
  localparam cfg_idx_t REG_MIX_MATRIX = 3'd1;
  localparam cfg_idx_t REG_RC_A       = 3'd2;
  localparam cfg_idx_t REG_RC_B       = 3'd3;
  localparam cfg_idx_t REG_RC_C       = 3'd4;
  localparam cfg_idx_t REG_RC_D       = 3'd5;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // nibble 0 sits in the top bits
  function automatic logic [3:0] nib(input block_t v, input int idx);
    return v[63-4*idx -: 4];
  endfunction

  // multiply in GF(16), x^4+x+1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = '0;
    x   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/led64_round.sv @@
// One LED-64 round: optional key add, constants, S-box, row rotation, column mix.
`timescale 1ns / 1ps
`default_nettype none

module led64_round (
  input  led64_pkg::block_t state_i,
  input  led64_pkg::block_t key_i,
  input  logic              add_key_i,
  input  led64_pkg::rc_t    rc_i,
  input  led64_pkg::block_t matrix_i,
  output led64_pkg::block_t state_o
);
  import led64_pkg::*;

  block_t     s_k;
  logic [3:0] s_c  [16];
  logic [3:0] s_sb [16];
  logic [3:0] s_sr [16];
  logic [3:0] half;
  logic [3:0] acc;

  always_comb begin
    s_k = add_key_i ? (state_i ^ key_i) : state_i;
    for (int i = 0; i < 16; i++) begin
      s_c[i] = nib(s_k, i);
    end
    for (int row = 0; row < 4; row++) begin
      half = (row % 2 == 1) ? {1'b0, rc_i[2:0]} : {1'b0, rc_i[5:3]};
      s_c[row*4]   = s_c[row*4] ^ 4'(row);
      s_c[row*4+1] = s_c[row*4+1] ^ half;
    end
    for (int i = 0; i < 16; i++) begin
      s_sb[i] = SBOX[s_c[i]];
    end
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        s_sr[row*4+col] = s_sb[row*4+((col+row)%4)];
      end
    end
    state_o = '0;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc ^= gf_mul(nib(matrix_i, row*4+k), s_sr[k*4+col]);
        end
        state_o[63-4*(row*4+col) -: 4] = acc;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/led64_block_encrypt.sv @@
// LED-64 encryptor top level: config registers, round pipeline, output skid.
`timescale 1ns / 1ps
`default_nettype none

// LED-64 encryption, 64-bit key. One round per register stage: round 0 works
// straight on plaintext_i and lands in the first of 32 round registers, and the
// output register follows the last one. A new block is taken every cycle while
// in_stall_o is low. A two-entry output buffer (output register plus skid
// register) lets the pipeline keep moving while the downstream side stalls,
// until the skid register fills; in_stall_o rises only once the skid
// register is full. Write the configuration registers only while no block is
// in flight.
module led64_block_encrypt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  led64_pkg::cfg_idx_t cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [63:0]         plaintext_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [63:0]         ciphertext_o
);
  import led64_pkg::*;

  `include "led64_block_encrypt_defines.svh"

  localparam int Last = ROUND_COUNT - 1;

  block_t      key_q, matrix_q;
  logic [59:0] rc_a_q, rc_b_q, rc_c_q;
  logic [11:0] rc_d_q;
  logic [RC_SLOTS*RC_W-1:0] rc_all;

  block_t st_q  [ROUND_COUNT];
  logic   vld_q [ROUND_COUNT];
  logic   en;

  block_t out_data_q, skid_data_q, last_data;
  logic   out_valid_q, skid_valid_q, last_valid;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      matrix_q <= '0;
      rc_a_q   <= '0;
      rc_b_q   <= '0;
      rc_c_q   <= '0;
      rc_d_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CIPHER_KEY: key_q    <= cfg_data_i;
        REG_MIX_MATRIX: matrix_q <= cfg_data_i;
        REG_RC_A:       rc_a_q   <= cfg_data_i[59:0];
        REG_RC_B:       rc_b_q   <= cfg_data_i[59:0];
        REG_RC_C:       rc_c_q   <= cfg_data_i[59:0];
        REG_RC_D:       rc_d_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign rc_all = {rc_d_q, rc_c_q, rc_b_q, rc_a_q};

  // pipeline moves unless the skid register is occupied
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    localparam int   RcIdx  = g % RC_SLOTS;
    localparam logic AddKey = (g % 4 == 0);
    block_t stage_in, stage_out;
    logic   valid_in;

    if (g == 0) begin : g_first
      assign stage_in = plaintext_i;
      assign valid_in = in_valid_i;
    end else begin : g_next
      assign stage_in = st_q[g-1];
      assign valid_in = vld_q[g-1];
    end

    led64_round u_round (
      .state_i   (stage_in),
      .key_i     (key_q),
      .add_key_i (AddKey),
      .rc_i      (rc_all[RcIdx*RC_W +: RC_W]),
      .matrix_i  (matrix_q),
      .state_o   (stage_out)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) st_q[g] <= stage_out;
    end
  end

  // final key whitening on the way out
  assign last_data  = st_q[Last] ^ key_q;
  assign last_valid = vld_q[Last] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q || last_valid;
      skid_valid_q <= 1'b0;
    end else if (last_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : last_data;
    end else if (last_valid) begin
      skid_data_q <= last_data;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ciphertext_o = out_data_q;

  `LED64_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q,
    "skid register holds a transaction while the output register is empty")
  `LED64_ASSERT(a_frozen_when_full, skid_valid_q |=> $stable(vld_q[Last]),
    "pipeline advanced while the skid register was full")
  `LED64_ASSERT(a_drain_empty,
    (out_valid_q && !out_stall_i && !skid_valid_q && !vld_q[Last]) |=> !out_valid_q,
    "output stayed valid after its transaction left with nothing behind it")

endmodule

`default_nettype wire
